>>> rtl/core/dmx_frame_receiver_with_length_lock_assert.svh
// ----------------------------------------------------------------------------
// dmx frame receiver assertion macros
// short forms for clocked assertions on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef DMX_FRAME_RECEIVER_WITH_LENGTH_LOCK_ASSERT_SVH
`define DMX_FRAME_RECEIVER_WITH_LENGTH_LOCK_ASSERT_SVH

// same-cycle implication
`define DMXFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmxfr assertion failed");

// next-cycle implication
`define DMXFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmxfr assertion failed");

`endif

>>> rtl/core/dmxfr_pkg.sv
// ----------------------------------------------------------------------------
// dmxfr_pkg
// shared types and constants of the dmx frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmxfr_pkg;

  localparam int SLOT_INDEX_W = 9;
  localparam int FRAME_LEN_W  = 10;
  localparam int BYTE_W       = 8;
  localparam int CFG_W        = 4;

  localparam logic [CFG_W-1:0] LOCK_MATCHES_RST = 4'd3;
  localparam logic [CFG_W-1:0] MATCH_MAX        = 4'd15;

  // operation codes of an input item
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_BREAK = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_TOO_LONG  = 2'd1,
    EV_TOO_SHORT = 2'd2,
    EV_LOCKED    = 2'd3
  } lock_ev_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_BREAK = 3'b010,
    PH_RECV  = 3'b100
  } phase_t;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic                    has_result;
    logic                    slot_valid;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [BYTE_W-1:0]       slot_value;
    logic                    frame_end;
    logic [FRAME_LEN_W-1:0]  frame_length;
    logic                    lock_state;
    lock_ev_t                lock_event;
  } step_res_t;

endpackage

>>> rtl/core/dmxfr_in_if.sv
// ----------------------------------------------------------------------------
// dmxfr_in_if
// receive item channel: a data byte or a break
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmxfr_in_if import dmxfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

>>> rtl/core/dmxfr_out_if.sv
// ----------------------------------------------------------------------------
// dmxfr_out_if
// result item channel: slot byte, frame end and lock status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmxfr_out_if import dmxfr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    slot_valid;
  logic [SLOT_INDEX_W-1:0] slot_index;
  logic [BYTE_W-1:0]       slot_value;
  logic                    frame_end;
  logic [FRAME_LEN_W-1:0]  frame_length;
  logic                    lock_state;
  logic [1:0]              lock_event;

  modport source (
    output valid, output slot_valid, output slot_index, output slot_value,
    output frame_end, output frame_length, output lock_state, output lock_event,
    input ready
  );
  modport sink (
    input valid, input slot_valid, input slot_index, input slot_value,
    input frame_end, input frame_length, input lock_state, input lock_event,
    output ready
  );
endinterface

>>> rtl/core/dmxfr_in_stage.sv
// ----------------------------------------------------------------------------
// dmxfr_in_stage
// input register holding one receive item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmxfr_in_stage import dmxfr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  rx_item_t src_item,
  input  logic     take,
  output logic     held_valid,
  output rx_item_t held_item
);

  // empty, or the held item leaves this cycle
  assign src_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (src_ready) begin
      held_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      held_item <= src_item;
    end
  end

endmodule

>>> rtl/core/dmxfr_frame_track.sv
// ----------------------------------------------------------------------------
// dmxfr_frame_track
// slot counting, frame length tracking and lock logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dmx_frame_receiver_with_length_lock_assert.svh"

module dmxfr_frame_track import dmxfr_pkg::*; #(
  parameter int FRAME_MAX = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             fire,
  input  rx_item_t         item,
  output step_res_t        res
);

  localparam int CW = $clog2(FRAME_MAX + 1);
  localparam logic [CW-1:0] FRAME_MAX_C = CW'(FRAME_MAX);

  logic [CFG_W-1:0] lock_matches;
  logic [CW-1:0]    slot_count, slot_count_next;
  phase_t           phase, phase_next;
  logic             locked_flag, locked_flag_next;
  logic [CFG_W-1:0] match_count, match_count_next;
  logic [CW-1:0]    locked_length, locked_length_next;

  logic [CW-1:0]    count_inc;
  logic [CFG_W-1:0] match_bumped;
  lock_ev_t         ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_matches <= LOCK_MATCHES_RST;
    end else if (cfg_we) begin
      lock_matches <= cfg_wdata;
    end
  end

  assign count_inc = slot_count + CW'(1);

  always_comb begin
    slot_count_next    = slot_count;
    phase_next         = phase;
    locked_flag_next   = locked_flag;
    match_count_next   = match_count;
    locked_length_next = locked_length;
    match_bumped       = match_count;
    ev                 = EV_NONE;
    res                = '0;

    if (item.operation == OP_BYTE) begin
      // byte after a length-ended frame: frame ran too long
      if (locked_flag && phase == PH_IDLE) begin
        match_count_next   = '0;
        locked_flag_next   = 1'b0;
        locked_length_next = slot_count;
        ev                 = EV_TOO_LONG;
      end
      phase_next = PH_RECV;
      if (slot_count < FRAME_MAX_C) begin
        res.slot_valid  = 1'b1;
        res.slot_index  = SLOT_INDEX_W'(slot_count);
        res.slot_value  = item.rx_byte;
        slot_count_next = count_inc;
        // locked: frame ends on length alone
        if (locked_flag_next && count_inc == locked_length_next) begin
          res.frame_end    = 1'b1;
          res.frame_length = FRAME_LEN_W'(count_inc);
          slot_count_next  = '0;
          phase_next       = PH_IDLE;
        end
      end
    end else begin
      if (slot_count != '0) begin
        if (locked_flag) begin
          if (locked_length != slot_count) begin
            match_count_next   = '0;
            locked_flag_next   = 1'b0;
            locked_length_next = slot_count;
            ev                 = EV_TOO_SHORT;
          end
        end else begin
          if (locked_length == slot_count && match_count != MATCH_MAX) begin
            match_bumped = match_count + CFG_W'(1);
          end
          match_count_next = match_bumped;
          if (match_bumped > lock_matches) begin
            locked_flag_next = 1'b1;
            ev               = EV_LOCKED;
          end
          locked_length_next = slot_count;
        end
        res.frame_end    = 1'b1;
        res.frame_length = FRAME_LEN_W'(slot_count);
      end
      phase_next      = PH_BREAK;
      slot_count_next = '0;
    end

    res.lock_state = locked_flag_next;
    res.lock_event = ev;
    res.has_result = res.slot_valid || res.frame_end || (ev != EV_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= '0;
      phase         <= PH_IDLE;
      locked_flag   <= 1'b0;
      match_count   <= '0;
      locked_length <= '0;
    end else if (fire) begin
      slot_count    <= slot_count_next;
      phase         <= phase_next;
      locked_flag   <= locked_flag_next;
      match_count   <= match_count_next;
      locked_length <= locked_length_next;
    end
  end

  `DMXFR_ASSERT_NOW(a_count_in_range, 1'b1, slot_count <= FRAME_MAX_C)
  `DMXFR_ASSERT_NOW(a_locked_len_nonzero, locked_flag, locked_length != '0)
  `DMXFR_ASSERT_NOW(a_locked_count_below_len, locked_flag, slot_count < locked_length)
  `DMXFR_ASSERT_NEXT(a_lock_event_sets_flag, fire && res.lock_event == EV_LOCKED, locked_flag)

endmodule

>>> rtl/core/dmxfr_out_stage.sv
// ----------------------------------------------------------------------------
// dmxfr_out_stage
// result register toward the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmxfr_out_stage import dmxfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  step_res_t load_res,
  output logic      can_load,
  output logic      res_valid,
  input  logic      res_ready,
  output step_res_t res
);

  assign can_load = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res <= load_res;
    end
  end

endmodule

>>> rtl/core/dmx_frame_receiver_with_length_lock.sv
// ----------------------------------------------------------------------------
// dmx_frame_receiver_with_length_lock
// dmx512 slot receiver with frame length lock
// ----------------------------------------------------------------------------
// takes receive items (a data byte or a line break) and gives one result item
// per item with a slot byte, a frame end or a lock change to report. one item
// is accepted every clock cycle unless the output stalls; results pass the
// input register, then the result register, and an output stall holds the
// input register so the block backs up one item at a time. bytes beyond
// FRAME_MAX slots in a frame are dropped. after more than lock_matches breaks
// that close frames of the same length, the block locks and closes each frame
// as soon as that many slots arrived; a byte after such a frame (too long) or
// a break before the length (too short) drops the lock. lock_matches may only
// be written while no item is in flight. there is no clearing pass after rst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmx_frame_receiver_with_length_lock import dmxfr_pkg::*; #(
  parameter int FRAME_MAX = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  dmxfr_in_if.sink         rx_items,
  dmxfr_out_if.source      slot_items
);

  // input register
  rx_item_t  src_item;
  rx_item_t  held_item;
  logic      held_valid;

  // handshake between the stages
  logic      can_load;
  logic      take;

  // step result and registered result
  step_res_t step_res;
  step_res_t out_res;
  logic      out_valid;

  assign src_item.operation = rx_items.operation;
  assign src_item.rx_byte   = rx_items.rx_byte;

  // held item is processed once the result register can take its result;
  // items with nothing to report still update the frame state
  assign take = held_valid && can_load;

  dmxfr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (rx_items.valid),
    .src_ready  (rx_items.ready),
    .src_item   (src_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // slot count, frame length match and lock state
  dmxfr_frame_track #(
    .FRAME_MAX (FRAME_MAX)
  ) u_frame_track (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (take),
    .item      (held_item),
    .res       (step_res)
  );

  // only steps with something to report load the result register
  dmxfr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (take && step_res.has_result),
    .load_res  (step_res),
    .can_load  (can_load),
    .res_valid (out_valid),
    .res_ready (slot_items.ready),
    .res       (out_res)
  );

  assign slot_items.valid        = out_valid;
  assign slot_items.slot_valid   = out_res.slot_valid;
  assign slot_items.slot_index   = out_res.slot_index;
  assign slot_items.slot_value   = out_res.slot_value;
  assign slot_items.frame_end    = out_res.frame_end;
  assign slot_items.frame_length = out_res.frame_length;
  assign slot_items.lock_state   = out_res.lock_state;
  assign slot_items.lock_event   = out_res.lock_event;

endmodule
